[rtl/tsb_pkg.sv]
// Shared types and constants for the ternary symbol string to binary unit.
`default_nettype none

package tsb_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int OUT_VALUE_W = 64;

    localparam logic [7:0] SEP_BYTE   = 8'h20;
    localparam logic [7:0] SYM_MINUS  = 8'h2D;
    localparam logic [7:0] SYM_ZERO   = 8'h30;
    localparam logic [7:0] SYM_PLUS   = 8'h2B;
    localparam logic [7:0] MAX_COUNT  = 8'd200;
    localparam logic [7:0] MAX_DIGITS = 8'd40;

    typedef enum logic [2:0] {
        ST_OK  = 3'd0,
        ST_LEN = 3'd1,
        ST_BAD = 3'd2,
        ST_BIG = 3'd3,
        ST_CNT = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] sym_byte;
        logic       end_of_string;
    } sym_item_t;

    typedef struct packed {
        logic [OUT_VALUE_W-1:0] value;
        logic [2:0]             status;
    } res_item_t;

endpackage

`default_nettype wire

[rtl/tsb_in_stage.sv]
// Input register stage that holds one accepted symbol item.
`default_nettype none

module tsb_in_stage
    import tsb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      sym_valid,
    output logic           sym_ready,
    input  wire sym_item_t sym,
    input  wire logic      take,
    output logic           item_valid,
    output sym_item_t      item
);

    logic      valid_reg;
    logic      valid_next;
    sym_item_t item_reg;

    // The register frees up in the same cycle that the core takes its item.
    assign sym_ready  = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (sym_valid && sym_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sym_valid && sym_ready)
        begin
            item_reg <= sym;
        end
    end

endmodule

`default_nettype wire

[rtl/tsb_core.sv]
// Tokenizer, digit check and base-3 accumulator with the length register.
`default_nettype none

module tsb_core
    import tsb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_data,
    input  wire logic       item_valid,
    input  wire sym_item_t  item,
    input  wire logic       out_free,
    output logic            take,
    output logic            res_load,
    output res_item_t       res_data
);

    logic [7:0]             exp_reg;
    logic                   in_token_reg;
    logic                   in_token_next;
    logic [1:0]             tok_len_reg;
    logic [1:0]             tok_len_next;
    logic [7:0]             tok_first_reg;
    logic [7:0]             tok_first_next;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] acc_next;
    logic [7:0]             pos_reg;
    logic [7:0]             pos_next;
    status_t                err_reg;
    status_t                err_next;

    logic                   is_sep;
    logic                   c_in;
    logic [1:0]             c_len;
    logic [7:0]             c_first;
    logic                   digit_ok;
    logic [1:0]             digit;
    logic [7:0]             remaining;
    status_t                status;

    // Only the last byte of a string produces an item, so other bytes never stall.
    assign take     = item_valid && (!item.end_of_string || out_free);
    assign res_load = take && item.end_of_string;

    always_comb
    begin
        is_sep = (item.sym_byte == SEP_BYTE);

        // Token state after this byte, before any close.
        if (is_sep)
        begin
            c_in    = in_token_reg;
            c_len   = tok_len_reg;
            c_first = tok_first_reg;
        end
        else if (!in_token_reg)
        begin
            c_in    = 1'b1;
            c_len   = 2'd1;
            c_first = item.sym_byte;
        end
        else
        begin
            c_in    = 1'b1;
            c_len   = (tok_len_reg == 2'd2) ? 2'd2 : tok_len_reg + 2'd1;
            c_first = tok_first_reg;
        end

        digit_ok = 1'b0;
        digit    = 2'd0;
        if (c_len == 2'd1)
        begin
            unique case (c_first)
                SYM_MINUS:
                begin
                    digit_ok = 1'b1;
                    digit    = 2'd0;
                end
                SYM_ZERO:
                begin
                    digit_ok = 1'b1;
                    digit    = 2'd1;
                end
                SYM_PLUS:
                begin
                    digit_ok = 1'b1;
                    digit    = 2'd2;
                end
                default:
                begin
                    digit_ok = 1'b0;
                    digit    = 2'd0;
                end
            endcase
        end

        // Only used when pos_reg is below exp_reg, so this never wraps.
        remaining = exp_reg - pos_reg - 8'd1;

        in_token_next  = c_in;
        tok_len_next   = c_len;
        tok_first_next = c_first;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        err_next       = err_reg;

        if (is_sep || item.end_of_string)
        begin
            in_token_next = 1'b0;
            tok_len_next  = 2'd0;
            if (c_in && (err_reg == ST_OK) && (pos_reg < exp_reg))
            begin
                if (!digit_ok)
                begin
                    err_next = ST_BAD;
                end
                else if (remaining >= MAX_DIGITS)
                begin
                    err_next = ST_BIG;
                end
                else
                begin
                    acc_next = (acc_reg << 1) + acc_reg
                             + VALUE_WIDTH'(digit);
                    pos_next = pos_reg + 8'd1;
                end
            end
        end

        priority if (exp_reg > MAX_COUNT)
        begin
            status = ST_LEN;
        end
        else if (err_next != ST_OK)
        begin
            status = err_next;
        end
        else if (pos_next != exp_reg)
        begin
            status = ST_CNT;
        end
        else
        begin
            status = ST_OK;
        end

        res_data.status = status;
        res_data.value  = (status == ST_OK) ? OUT_VALUE_W'(acc_next) : '0;

        // Per-string state starts over after the last byte.
        if (item.end_of_string)
        begin
            in_token_next  = 1'b0;
            tok_len_next   = 2'd0;
            tok_first_next = 8'd0;
            acc_next       = '0;
            pos_next       = 8'd0;
            err_next       = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg       <= 8'd0;
            in_token_reg  <= 1'b0;
            tok_len_reg   <= 2'd0;
            tok_first_reg <= 8'd0;
            acc_reg       <= '0;
            pos_reg       <= 8'd0;
            err_reg       <= ST_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                exp_reg <= cfg_data;
            end
            if (take)
            begin
                in_token_reg  <= in_token_next;
                tok_len_reg   <= tok_len_next;
                tok_first_reg <= tok_first_next;
                acc_reg       <= acc_next;
                pos_reg       <= pos_next;
                err_reg       <= err_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/tsb_out_stage.sv]
// Result register that holds one finished item until it is taken.
`default_nettype none

module tsb_out_stage
    import tsb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      res_load,
    input  wire res_item_t res_data,
    output logic           out_free,
    output logic           res_valid,
    input  wire logic      res_ready,
    output res_item_t      res
);

    logic      valid_reg;
    logic      valid_next;
    res_item_t res_reg;

    assign out_free  = !valid_reg || res_ready;
    assign res_valid = valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_load)
        begin
            valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_data;
        end
    end

endmodule

`default_nettype wire

[rtl/ternary_symbol_string_to_binary_unit.sv]
// Top level of the ternary symbol string to binary unit.
// Path: a last byte goes from the input register through the core into the result register.
// Throughput: one byte item per cycle while a last byte finds room in the result register,
// set by the combinational accumulate step (multiply by three as a shift and add).
// Reset: rst_n is asynchronous and active low; it clears the length register to 0,
// all per-string state, and both valid flags.
`default_nettype none

module ternary_symbol_string_to_binary_unit
    import tsb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_data,
    input  wire logic       sym_valid,
    output logic            sym_ready,
    input  wire sym_item_t  sym,
    output logic            res_valid,
    input  wire logic       res_ready,
    output res_item_t       res
);

    logic      item_valid;
    sym_item_t item;
    logic      take;
    logic      res_load;
    res_item_t res_data;
    logic      out_free;

    // The input register decouples the byte source from the accumulator.
    tsb_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .sym_valid  (sym_valid),
        .sym_ready  (sym_ready),
        .sym        (sym),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // The core tokenizes, checks each token and folds valid digits into the value.
    // A non-final byte is always taken; the final byte waits for room in the
    // result register.
    tsb_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .res_load   (res_load),
        .res_data   (res_data)
    );

    // The result register lets the next string proceed while a result waits.
    tsb_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res_data  (res_data),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // A result is only loaded when the result register has room for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free)
        else $error("result loaded into an occupied result register");

    // A failed string always reports a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status != ST_OK)) |-> (res.value == '0))
        else $error("nonzero value with an error status");

    // Status codes stay within the defined set.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.status <= ST_CNT))
        else $error("undefined status code");

    // Input backpressure only comes from a held item that cannot move on.
    assert property (@(posedge clk) disable iff (!rst_n)
        !sym_ready |-> (item_valid && item.end_of_string && !out_free))
        else $error("input stalled without a blocked final item");

endmodule

`default_nettype wire

[tb/tsb_tb_pkg.sv]
// Scoreboard and conversion predictor for the ternary symbol string testbench.
package tsb_tb_pkg;

    import tsb_pkg::*;

    class tsb_conversion_scoreboard;

        // Copy of the length register and of the per-string state.
        logic [7:0]  digit_count;
        bit          in_token;
        int unsigned token_len;
        logic [7:0]  token_first;
        logic [63:0] accum;
        logic [7:0]  digits_taken;
        status_t     string_error;

        res_item_t   pending_conversions[$];
        int unsigned mismatches;
        int unsigned bytes_seen;
        int unsigned results_checked;
        int unsigned status_hits[5];

        function new();
            digit_count = '0;
            mismatches = 0;
            bytes_seen = 0;
            results_checked = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
            clear_string();
        endfunction

        function void clear_string();
            in_token = 1'b0;
            token_len = 0;
            token_first = '0;
            accum = '0;
            digits_taken = '0;
            string_error = ST_OK;
        endfunction

        function void set_count(logic [7:0] count);
            digit_count = count;
        endfunction

        // A token ends: turn it into a digit if one is still owed.
        function void close_token();
            logic [1:0] digit;
            bit         is_digit;
            if (!in_token) return;
            in_token = 1'b0;
            if (string_error != ST_OK || digits_taken >= digit_count) begin
                token_len = 0;
                return;
            end
            digit = '0;
            is_digit = 1'b0;
            if (token_len == 1) begin
                case (token_first)
                    SYM_MINUS: begin digit = 2'd0; is_digit = 1'b1; end
                    SYM_ZERO:  begin digit = 2'd1; is_digit = 1'b1; end
                    SYM_PLUS:  begin digit = 2'd2; is_digit = 1'b1; end
                    default:   is_digit = 1'b0;
                endcase
            end
            token_len = 0;
            if (!is_digit)
                string_error = ST_BAD;
            else if (int'(digit_count) - int'(digits_taken) - 1 >= int'(MAX_DIGITS))
                string_error = ST_BIG;
            else begin
                accum = accum * 64'd3 + 64'(digit);
                digits_taken = digits_taken + 8'd1;
            end
        endfunction

        // Called for every accepted byte item; queues a result on the last byte.
        function void note_byte(sym_item_t item);
            status_t   st;
            res_item_t want;
            bytes_seen++;
            if (item.sym_byte == SEP_BYTE)
                close_token();
            else if (!in_token) begin
                in_token = 1'b1;
                token_first = item.sym_byte;
                token_len = 1;
            end else if (token_len < 2)
                token_len++;
            if (!item.end_of_string) return;
            close_token();
            if (digit_count > MAX_COUNT)
                st = ST_LEN;
            else if (string_error != ST_OK)
                st = string_error;
            else if (digits_taken != digit_count)
                st = ST_CNT;
            else
                st = ST_OK;
            want.value = (st == ST_OK) ? accum : '0;
            want.status = st;
            pending_conversions.push_back(want);
            status_hits[int'(st)]++;
            clear_string();
        endfunction

        function void check_result(res_item_t got, realtime now);
            res_item_t want;
            if (pending_conversions.size() == 0) begin
                $display("[%0.1f ns] result with none pending: value %0d status %0d",
                         now, got.value, got.status);
                mismatches++;
                return;
            end
            want = pending_conversions.pop_front();
            results_checked++;
            if (got.value !== want.value) begin
                $display("[%0.1f ns] value mismatch: expected %0d, got %0d",
                         now, want.value, got.value);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $display("[%0.1f ns] status mismatch: expected %0d, got %0d",
                         now, want.status, got.status);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_conversions.size();
        endfunction

    endclass

endpackage

[tb/tb_ternary_symbol_string_to_binary_unit.sv]
// Top-level testbench for the ternary symbol string to binary unit.
module tb_ternary_symbol_string_to_binary_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import tsb_pkg::*;
    import tsb_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1160;
    localparam int DRAIN_CYCLES = 4;   // spare cycles before a length write
    localparam int HOLD_CYCLES  = 250; // long receiver hold-off for back-pressure

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_data;
    logic        sym_valid;
    logic        sym_ready;
    sym_item_t   sym;
    logic        res_valid;
    logic        res_ready;
    res_item_t   res;

    tsb_conversion_scoreboard sb = new();

    // Bytes of the string being built; the last one carries end_of_string.
    logic [7:0]  text_q[$];
    int unsigned total_items;
    int unsigned random_items;
    int unsigned count_writes;
    // When set, neither side inserts idle cycles.
    bit          no_idle;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit          hold_request;

    ternary_symbol_string_to_binary_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .sym       (sym),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Most gaps are zero or short, a few are long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [7:0] digit_char(int d);
        case (d)
            0:       return SYM_MINUS;
            1:       return SYM_ZERO;
            default: return SYM_PLUS;
        endcase
    endfunction

    // Offer one byte item and hold it until the block takes it. Inputs move on
    // the falling edge; sym_ready is sampled at the rising edge, so the item
    // is noted as accepted exactly when the block takes it.
    task automatic send_symbol(input sym_item_t item);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            sym_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sym_valid = 1'b1;
        sym = item;
        do @(posedge clk); while (!sym_ready);
        sb.note_byte(item);
        total_items++;
    endtask

    // Send the queued string, marking its last byte, and empty the queue.
    task automatic send_text();
        sym_item_t item;
        foreach (text_q[i])
        begin
            item.sym_byte = text_q[i];
            item.end_of_string = (i == text_q.size() - 1);
            send_symbol(item);
        end
        text_q.delete();
    endtask

    task automatic send_literal(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
        send_text();
    endtask

    // The length register may only change while the block is idle: stop
    // offering bytes, let every pending result come back, give the pipeline
    // a few spare cycles, then write the register for one clock.
    task automatic change_count(input logic [7:0] count);
        @(negedge clk);
        sym_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_data = count;
        @(posedge clk);
        sb.set_count(count);
        count_writes++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic push_spaces(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) text_q.push_back(SEP_BYTE);
    endtask

    // A token that is never a digit: two or three characters, or one byte
    // that is not a symbol (a random byte may still hit a symbol by chance).
    task automatic push_bad_token();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == SEP_BYTE) b = 8'h21;
        case ($urandom_range(0, 2))
            0:
            begin
                text_q.push_back(digit_char($urandom_range(0, 2)));
                text_q.push_back(digit_char($urandom_range(0, 2)));
            end
            1: text_q.push_back(b);
            default:
            begin
                text_q.push_back(b);
                text_q.push_back(digit_char($urandom_range(0, 2)));
                if ($urandom_range(0, 1)) text_q.push_back(b);
            end
        endcase
    endtask

    // Build a string of n tokens; token number bad_pos is malformed (none
    // if negative). Separators are one to three spaces, with optional
    // leading and trailing spaces.
    task automatic build_tokens(input int n, input int bad_pos, input bit all_plus);
        if ($urandom_range(0, 3) == 0) push_spaces(1, 2);
        for (int i = 0; i < n; i++)
        begin
            if (i == bad_pos)
                push_bad_token();
            else
                text_q.push_back(all_plus ? SYM_PLUS : digit_char($urandom_range(0, 2)));
            if (i != n - 1)
                push_spaces(1, ($urandom_range(0, 4) == 0) ? 3 : 1);
        end
        if (n == 0 || $urandom_range(0, 3) == 0) push_spaces(1, 2);
    endtask

    // One random string for the current length setting. Most strings are
    // well formed with random digits so that the accumulator gets exercised
    // at every length; the rest are broken strings and raw byte noise.
    task automatic build_random_string(input int count);
        int r;
        int n;
        int k;
        r = $urandom_range(0, 99);
        if (count > 40)
            n = $urandom_range(0, 3);
        else
        begin
            k = $urandom_range(0, 9);
            if (k < 6)       n = count;
            else if (k == 6) n = count + $urandom_range(1, 3);
            else if (k == 7) n = (count > 0) ? count - 1 : 0;
            else             n = $urandom_range(0, count);
        end
        if (r < 8)
            text_q.push_back(SEP_BYTE);
        else if (r < 70)
            build_tokens(n, -1, $urandom_range(0, 3) == 0);
        else if (r < 85)
        begin
            if (n == 0) n = 1;
            build_tokens(n, $urandom_range(0, n - 1), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 12))
            begin
                case ($urandom_range(0, 2))
                    0:       text_q.push_back(SEP_BYTE);
                    1:       text_q.push_back(digit_char($urandom_range(0, 2)));
                    default: text_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    // Receiver: accepts by default, stalls now and then, and serves one long
    // hold-off on request. The hold-off is counted here, in cycles, while the
    // sender keeps offering bytes, so the block fills up and stalls its input.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        res_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                res_ready = 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                res_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                res_ready = 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // Every accepted result item goes straight to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(res, $realtime);
    end

    // Stimulus: reset, a directed pass over the special cases, a back-pressure
    // burst, then random phases at a spread of length settings.
    initial
    begin
        logic [7:0] fixed_counts[$];
        int         phase;
        int         phase_items;
        int         phase_len;
        int         count;
        int         r;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        sym_valid = 1'b0;
        sym = '0;
        no_idle = 1'b0;
        hold_request = 1'b0;
        total_items = 0;
        random_items = 0;
        count_writes = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // With the reset length of zero, an empty string is fine and any
        // token is ignored since enough digits are already present.
        send_literal(" ");
        send_literal("+");

        change_count(8'd3);
        send_literal("- 0 +");

        change_count(8'd2);
        send_literal("++ +");           // two-character token is invalid
        send_literal("x +");            // first error wins over later digits
        send_literal("+");              // too few digits

        change_count(8'd1);
        text_q.push_back(8'h00);
        send_text();                    // NUL is a token character, not a digit
        text_q.push_back(8'hFF);
        send_text();
        send_literal("0 ");
        send_literal("+ x");            // tokens after the last digit are unchecked

        change_count(8'd41);
        send_literal("+");              // more than forty digits would be needed
        send_literal("x");              // invalid token beats the digit limit

        change_count(8'd201);
        send_literal(" ");              // length over the limit
        change_count(8'd255);
        send_literal("+");

        // Back-pressure: single-byte strings, each giving a result, offered
        // without gaps while the receiver holds off for a long stretch.
        change_count(8'd1);
        no_idle = 1'b1;
        @(posedge clk);
        hold_request = 1'b1;
        repeat (60)
        begin
            text_q.push_back(($urandom_range(0, 2) == 0) ? SEP_BYTE
                                                       : digit_char($urandom_range(0, 2)));
            send_text();
        end
        no_idle = 1'b0;

        // Random phases. The first settings are fixed so that the extremes
        // always come up; later ones lean toward short digit counts.
        fixed_counts = '{8'd0, 8'd40, 8'd1, 8'd41, 8'd200, 8'd201, 8'd255, 8'd39, 8'd40};
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (phase < fixed_counts.size())
                count = int'(fixed_counts[phase]);
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)      count = $urandom_range(0, 8);
                else if (r < 85) count = $urandom_range(9, 40);
                else             count = $urandom_range(41, 255);
            end
            change_count(8'(count));
            no_idle = ($urandom_range(0, 4) == 0);
            phase_len = (count >= 30 && count <= 40) ? 160 : $urandom_range(40, 120);
            phase_items = 0;
            while (phase_items < phase_len)
            begin
                build_random_string(count);
                phase_items += text_q.size();
                random_items += text_q.size();
                send_text();
            end
            phase++;
        end
        no_idle = 1'b0;

        // Drain: every expected result must arrive, and nothing extra after.
        @(negedge clk);
        sym_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run covered %0d byte items and %0d results over %0d length settings.",
                 total_items, sb.results_checked, count_writes);
        $display("Results by status: ok %0d, length %0d, invalid %0d, too many %0d, count %0d.",
                 sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
                 sb.status_hits[3], sb.status_hits[4]);
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #3ms;
        $display("Timeout: run did not finish");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
